// ===== design/lle_pkg.sv =====
// lle_pkg: shared types, sizes and codes for the linked list engine.
// Used by lle_cell and linked_list_engine; depends on nothing.

package lle_pkg;

   // List size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int VAL_W    = 32;

   // Command codes
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [2:0] CMD_POP_BACK   = 3'd3;
   localparam logic [2:0] CMD_INSERT     = 3'd4;
   localparam logic [2:0] CMD_WALK       = 3'd5;

   // Status codes
   localparam logic [1:0] STS_OK      = 2'd0;
   localparam logic [1:0] STS_EMPTY   = 2'd1;
   localparam logic [1:0] STS_INVALID = 2'd2;
   localparam logic [1:0] STS_FULL    = 2'd3;

   // Cell operations
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_ROTATE = 2'd2;

   typedef struct packed {
      logic [2:0]              command;
      logic signed [VAL_W-1:0] value;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] element;
      logic                    last;
   } rsp_type;

   // Broadcast control from the sequencer to every cell
   typedef struct packed {
      logic [1:0]              op;
      logic [IDX_W-1:0]        pos;
      logic [IDX_W-1:0]        last_idx;
      logic signed [VAL_W-1:0] value;
   } cell_ctl_type;

endpackage

// ===== design/lle_cell.sv =====
// lle_cell: one slot of the list chain, holding the element at its list position.
// Depends on lle_pkg for the control struct and cell operation codes.

module lle_cell (
   input  logic                             clock,
   input  logic [lle_pkg::IDX_W-1:0]        cell_idx,
   input  lle_pkg::cell_ctl_type            ctl,
   input  logic signed [lle_pkg::VAL_W-1:0] left_value,
   input  logic signed [lle_pkg::VAL_W-1:0] right_value,
   input  logic signed [lle_pkg::VAL_W-1:0] head_value,
   output logic signed [lle_pkg::VAL_W-1:0] value_q
);
   import lle_pkg::*;

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   // Pick the next element: take the new value, shift from a neighbor, or hold
   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         CELL_INSERT: begin
            if (cell_idx == ctl.pos) begin
               value_in = ctl.value;
            end else if (cell_idx > ctl.pos) begin
               value_in = left_value;
            end
         end
         CELL_ROTATE: begin
            if (cell_idx == ctl.last_idx) begin
               value_in = head_value;
            end else if (cell_idx < ctl.last_idx) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q = value_ff;

endmodule

// ===== design/linked_list_engine.sv =====
// linked_list_engine: bounded singly linked list held in a chain of element cells.
// Depends on lle_pkg and lle_cell.
//
// The list is kept in list order in a row of CAPACITY cells, cell 0 being the head.
// Push front, push back and insert shift the cells at and above the insert point
// up by one; pop front rotates the occupied cells down one place and drops the
// count; pop back only drops the count. Each of these commands returns one beat.
// A walk rotates the occupied cells once per emitted beat and leaves the list as
// it was. A new command is taken only while no walk is running and the result
// register is empty or its beat leaves in the same cycle; a stalled result beat
// holds off the command port. Commands six and seven are dropped silently.

module linked_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lle_pkg::rsp_type rsp_data
);
   import lle_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_WALK = 1'b1;

   logic                    state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        remain_ff, remain_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    load;
   logic                    out_free;
   logic                    req_acc;
   logic                    is_full;
   logic                    is_empty;
   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] cell_q [CAPACITY];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != STATE_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);

   // Sequence commands and drive the cell chain
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      load         = 1'b0;
      rsp_in       = rsp_ff;
      ctl.op       = CELL_HOLD;
      ctl.pos      = IDX_W'(req_data.position);
      ctl.last_idx = IDX_W'(count_ff - 1'b1);
      ctl.value    = req_data.value;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_acc) begin
               rsp_in.status  = STS_OK;
               rsp_in.element = '0;
               rsp_in.last    = 1'b1;
               unique case (req_data.command) inside
                  CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
                     load = 1'b1;
                     if (is_full) begin
                        rsp_in.status = STS_FULL;
                     end else if (req_data.command == CMD_INSERT &&
                                  CMP_W'(req_data.position) > CMP_W'(count_ff)) begin
                        rsp_in.status = STS_INVALID;
                     end else begin
                        ctl.op   = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                        if (req_data.command == CMD_PUSH_FRONT) begin
                           ctl.pos = '0;
                        end else if (req_data.command == CMD_PUSH_BACK) begin
                           ctl.pos = IDX_W'(count_ff);
                        end
                     end
                  end
                  CMD_POP_FRONT: begin
                     load = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = STS_EMPTY;
                     end else begin
                        ctl.op   = CELL_ROTATE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_POP_BACK: begin
                     load = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = STS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_WALK: begin
                     if (is_empty) begin
                        load          = 1'b1;
                        rsp_in.status = STS_EMPTY;
                     end else begin
                        state_in  = STATE_WALK;
                        remain_in = count_ff;
                     end
                  end
                  default: load = 1'b0;
               endcase
            end
         end
         STATE_WALK: begin
            // Emit the head and rotate the next element into cell 0
            if (out_free) begin
               load           = 1'b1;
               rsp_in.status  = STS_OK;
               rsp_in.element = cell_q[0];
               rsp_in.last    = (remain_ff == CNT_W'(1));
               ctl.op         = CELL_ROTATE;
               remain_in      = remain_ff - 1'b1;
               if (remain_ff == CNT_W'(1)) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // Hold a result beat until taken, refill when free
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Chain of element cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] left_v;
      logic signed [VAL_W-1:0] right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_q[i+1];
      end
      lle_cell u_cell (
         .clock       (clock),
         .cell_idx    (IDX_W'(i)),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (cell_q[0]),
         .value_q     (cell_q[i])
      );
   end

   // Count stays within the chain
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // A walk only runs over a non-empty list and never past its length
   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_WALK |-> remain_ff != '0 && remain_ff <= count_ff)
      else $error("walk counter out of range");

   // A walk leaves the element count untouched
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == STATE_WALK |=> count_ff == $past(count_ff))
      else $error("count changed during walk");

   // Beats without last only come from a running walk
   a_last_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> state_ff == STATE_WALK)
      else $error("non-final beat outside a walk");

endmodule
